>>> src/assert_macros.svh
// Assertion macros for the top-level RTL file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion.
`define TTCP_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion, off while reset is high.
`define TTCP_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> src/ttcp_pkg.sv
// Shared types, constants and helpers for the triangle transform/cull/project block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttcp_pkg;

   typedef logic signed [31:0] q32_type;

   typedef struct packed {
      logic neg;
      logic ovf;
      logic zero;
   } div_ctl_type;

   localparam int ONE_Q16     = 65536;
   localparam logic signed [63:0] PUSH_DEPTH = 64'sd524288;
   localparam int SHADE_STEPS = 13;
   localparam int NRM_BITS    = 28;
   localparam int DIV_STEPS   = 33;
   localparam int DIV_LAT     = DIV_STEPS + 2;
   localparam logic [34:0] DIV3_RECIP = 35'd11453246123;
   localparam int DIV3_SHIFT  = 35;

   localparam logic [2:0] REG_COS_Z    = 3'd0;
   localparam logic [2:0] REG_SIN_Z    = 3'd1;
   localparam logic [2:0] REG_COS_X    = 3'd2;
   localparam logic [2:0] REG_SIN_X    = 3'd3;
   localparam logic [2:0] REG_X_SCALE  = 3'd4;
   localparam logic [2:0] REG_Y_SCALE  = 3'd5;
   localparam logic [2:0] REG_Z_SCALE  = 3'd6;
   localparam logic [2:0] REG_Z_OFFSET = 3'd7;

   localparam logic signed [17:0] RST_COS = 18'sd65536;
   localparam logic signed [17:0] RST_SIN = 18'sd0;
   localparam q32_type RST_X_SCALE  = 32'sd61440;
   localparam q32_type RST_Y_SCALE  = 32'sd65536;
   localparam q32_type RST_Z_SCALE  = 32'sd65543;
   localparam q32_type RST_Z_OFFSET = -32'sd6554;

   function automatic q32_type sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

>>> src/ttcp_if.sv
// Valid/ready channel interfaces: triangle request and projected result.
// Depends on ttcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ttcp_req_if;
   logic valid;
   logic ready;
   ttcp_pkg::q32_type v0_x, v0_y, v0_z;
   ttcp_pkg::q32_type v1_x, v1_y, v1_z;
   ttcp_pkg::q32_type v2_x, v2_y, v2_z;

   modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                   input ready);
   modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                 output ready);
endinterface

interface ttcp_rsp_if;
   logic valid;
   logic ready;
   ttcp_pkg::q32_type s0_x, s0_y, s1_x, s1_y, s2_x, s2_y;
   ttcp_pkg::q32_type depth;
   logic [3:0] shade;
   logic visible;

   modport source (output valid, s0_x, s0_y, s1_x, s1_y, s2_x, s2_y, depth, shade, visible,
                   input ready);
   modport sink (input valid, s0_x, s0_y, s1_x, s1_y, s2_x, s2_y, depth, shade, visible,
                 output ready);
endinterface

`default_nettype wire

>>> src/ttcp_div.sv
// Pipelined signed 64/32 divider, truncating, result saturated to 32 bits.
// Zero divisor gives the dividend shifted right 16. Depends on ttcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttcp_div (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [63:0]   num,
   input  wire logic signed [31:0]   den,
   output ttcp_pkg::q32_type         quo
);

   localparam int N = ttcp_pkg::DIV_STEPS;

   logic [31:0]               r_ff   [0:N];
   logic [31:0]               r_in   [0:N];
   logic [N-1:0]              lo_ff  [0:N];
   logic [N-1:0]              lo_in  [0:N];
   logic [N-1:0]              q_ff   [0:N];
   logic [N-1:0]              q_in   [0:N];
   logic [31:0]               d_ff   [0:N];
   ttcp_pkg::div_ctl_type     ctl_ff [0:N];
   ttcp_pkg::q32_type         alt_ff [0:N];
   ttcp_pkg::q32_type         quo_ff, quo_in;
   logic [63:0]               pmag;
   logic [31:0]               dmag;
   ttcp_pkg::div_ctl_type     ctl_in;
   ttcp_pkg::q32_type         alt_in;

   always_comb begin
      pmag   = num[63] ? 64'(-num) : 64'(num);
      dmag   = den[31] ? 32'(-den) : 32'(den);
      ctl_in.neg  = num[63] ^ den[31];
      ctl_in.ovf  = {1'b0, pmag[63:33]} >= dmag;
      ctl_in.zero = (den == 32'sd0);
      alt_in = ttcp_pkg::sat32(num >>> 16);
      r_in[0]  = {1'b0, pmag[63:33]};
      lo_in[0] = pmag[N-1:0];
      q_in[0]  = '0;
   end

   always_comb begin
      logic [32:0] raw;
      logic        ge;
      raw = '0;
      ge  = 1'b0;
      for (int k = 1; k <= N; k++) begin
         raw = {r_ff[k-1], lo_ff[k-1][N-1]};
         ge  = raw >= {1'b0, d_ff[k-1]};
         r_in[k]  = ge ? 32'(raw - {1'b0, d_ff[k-1]}) : raw[31:0];
         lo_in[k] = {lo_ff[k-1][N-2:0], 1'b0};
         q_in[k]  = {q_ff[k-1][N-2:0], ge};
      end
   end

   always_comb begin
      logic [N-1:0] q;
      q = q_ff[N];
      if (ctl_ff[N].zero) begin
         quo_in = alt_ff[N];
      end else if (ctl_ff[N].ovf) begin
         quo_in = ctl_ff[N].neg ? 32'sh80000000 : 32'sh7fffffff;
      end else if (ctl_ff[N].neg) begin
         quo_in = (q > 33'h080000000) ? 32'sh80000000 : 32'(-q);
      end else begin
         quo_in = (q > 33'h07fffffff) ? 32'sh7fffffff : q[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= r_in[0];
         lo_ff[0]  <= lo_in[0];
         q_ff[0]   <= q_in[0];
         d_ff[0]   <= dmag;
         ctl_ff[0] <= ctl_in;
         alt_ff[0] <= alt_in;
         for (int k = 1; k <= N; k++) begin
            r_ff[k]   <= r_in[k];
            lo_ff[k]  <= lo_in[k];
            q_ff[k]   <= q_in[k];
            d_ff[k]   <= d_ff[k-1];
            ctl_ff[k] <= ctl_ff[k-1];
            alt_ff[k] <= alt_ff[k-1];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

>>> src/triangle_transform_cull_project_top.sv
// Top level: rotate, cull, shade and project one triangle per beat.
// Depends on ttcp_pkg, ttcp_if, ttcp_div and assert_macros.svh.
// One triangle per cycle while the result register is empty or taken.
// Latency is set by the 33-step restoring divider pipeline for the perspective divide.
// Whole pipeline advances when the result register is empty or taken.
// Synchronous reset clears all valid bits and loads default register values.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangle_transform_cull_project_top #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ttcp_req_if.sink         req,
   ttcp_rsp_if.source       rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int ST_T   = 4;
   localparam int ST_C   = ST_T + 9;
   localparam int ST_V2  = ST_T + 2 + ttcp_pkg::DIV_LAT + 2;
   localparam int ST_OUT = ST_V2 + 1;
   localparam int CD     = ST_V2 - ST_C;
   localparam int SZ_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int SZW    = $clog2(SZ_MAX + 1) + 1;
   localparam int VPW    = 33 + SZW;
   localparam logic signed [SZW-1:0] SW_S = SZW'(SCREEN_WIDTH);
   localparam logic signed [SZW-1:0] SH_S = SZW'(SCREEN_HEIGHT);

   typedef struct packed {
      logic       vis;
      logic [3:0] shade;
   } cull_type;

   // configuration
   logic signed [17:0] cos_z_ff, sin_z_ff, cos_x_ff, sin_x_ff;
   ttcp_pkg::q32_type  x_scale_ff, y_scale_ff, z_scale_ff, z_offset_ff;
   logic               wr;

   assign wr     = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_z_ff    <= ttcp_pkg::RST_COS;
         sin_z_ff    <= ttcp_pkg::RST_SIN;
         cos_x_ff    <= ttcp_pkg::RST_COS;
         sin_x_ff    <= ttcp_pkg::RST_SIN;
         x_scale_ff  <= ttcp_pkg::RST_X_SCALE;
         y_scale_ff  <= ttcp_pkg::RST_Y_SCALE;
         z_scale_ff  <= ttcp_pkg::RST_Z_SCALE;
         z_offset_ff <= ttcp_pkg::RST_Z_OFFSET;
      end else if (wr) begin
         case (paddr[4:2])
            ttcp_pkg::REG_COS_Z:    cos_z_ff    <= pwdata[17:0];
            ttcp_pkg::REG_SIN_Z:    sin_z_ff    <= pwdata[17:0];
            ttcp_pkg::REG_COS_X:    cos_x_ff    <= pwdata[17:0];
            ttcp_pkg::REG_SIN_X:    sin_x_ff    <= pwdata[17:0];
            ttcp_pkg::REG_X_SCALE:  x_scale_ff  <= pwdata;
            ttcp_pkg::REG_Y_SCALE:  y_scale_ff  <= pwdata;
            ttcp_pkg::REG_Z_SCALE:  z_scale_ff  <= pwdata;
            ttcp_pkg::REG_Z_OFFSET: z_offset_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         ttcp_pkg::REG_COS_Z:    prdata = 32'(cos_z_ff);
         ttcp_pkg::REG_SIN_Z:    prdata = 32'(sin_z_ff);
         ttcp_pkg::REG_COS_X:    prdata = 32'(cos_x_ff);
         ttcp_pkg::REG_SIN_X:    prdata = 32'(sin_x_ff);
         ttcp_pkg::REG_X_SCALE:  prdata = x_scale_ff;
         ttcp_pkg::REG_Y_SCALE:  prdata = y_scale_ff;
         ttcp_pkg::REG_Z_SCALE:  prdata = z_scale_ff;
         ttcp_pkg::REG_Z_OFFSET: prdata = z_offset_ff;
         default:                prdata = '0;
      endcase
   end

   // pipeline control
   logic              adv;
   logic [1:ST_OUT]   vld_ff;

   assign adv       = !vld_ff[ST_OUT] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {req.valid, vld_ff[1:ST_OUT-1]};
      end
   end

   // rotation
   ttcp_pkg::q32_type vx [3], vy [3], vz [3];

   assign vx[0] = req.v0_x; assign vy[0] = req.v0_y; assign vz[0] = req.v0_z;
   assign vx[1] = req.v1_x; assign vy[1] = req.v1_y; assign vz[1] = req.v1_z;
   assign vx[2] = req.v2_x; assign vy[2] = req.v2_y; assign vz[2] = req.v2_z;

   logic signed [49:0] pa_ff [3], pb_ff [3], pc_ff [3], pd_ff [3];
   logic signed [49:0] pe_ff [3], pf_ff [3], pg_ff [3], ph_ff [3];
   ttcp_pkg::q32_type  z1_ff [3], z2_ff [3], rx_ff [3], ry_ff [3], rx3_ff [3];
   ttcp_pkg::q32_type  t_ff [3][3];
   ttcp_pkg::q32_type  rx_in [3], ry_in [3], ty_in [3], tz_in [3], tw_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rx_in[i] = ttcp_pkg::sat32(64'((51'(pa_ff[i]) - 51'(pb_ff[i])) >>> 16));
         ry_in[i] = ttcp_pkg::sat32(64'((51'(pc_ff[i]) + 51'(pd_ff[i])) >>> 16));
         ty_in[i] = ttcp_pkg::sat32(64'((51'(pe_ff[i]) - 51'(pf_ff[i])) >>> 16));
         tz_in[i] = ttcp_pkg::sat32(64'((51'(pg_ff[i]) + 51'(ph_ff[i])) >>> 16));
         tw_in[i] = ttcp_pkg::sat32(64'(tz_in[i]) + ttcp_pkg::PUSH_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pa_ff[i]  <= vx[i] * cos_z_ff;
            pb_ff[i]  <= vy[i] * sin_z_ff;
            pc_ff[i]  <= vx[i] * sin_z_ff;
            pd_ff[i]  <= vy[i] * cos_z_ff;
            z1_ff[i]  <= vz[i];
            rx_ff[i]  <= rx_in[i];
            ry_ff[i]  <= ry_in[i];
            z2_ff[i]  <= z1_ff[i];
            pe_ff[i]  <= ry_ff[i] * cos_x_ff;
            pf_ff[i]  <= z2_ff[i] * sin_x_ff;
            pg_ff[i]  <= ry_ff[i] * sin_x_ff;
            ph_ff[i]  <= z2_ff[i] * cos_x_ff;
            rx3_ff[i] <= rx_ff[i];
            t_ff[i][0] <= rx3_ff[i];
            t_ff[i][1] <= ty_in[i];
            t_ff[i][2] <= tw_in[i];
         end
      end
   end

   // cull and shade
   ttcp_pkg::q32_type  e1_ff [3], e2_ff [3];
   ttcp_pkg::q32_type  t0d_ff [ST_T+1:ST_T+6][3];
   logic signed [63:0] cp_ff [6];
   logic signed [63:0] n_ff [3], nb_ff [3], nc_ff [3];
   logic [63:0]        orv_ff;
   logic [7:0]         grp_ff;
   logic [5:0]         sh_ff, sh_in;
   logic signed [ttcp_pkg::NRM_BITS-1:0] a_ff [3];
   logic signed [59:0] dp_ff [3];
   logic [55:0]        sq_ff [3];
   logic               negz7_ff, negz8_ff, vis8_ff;
   logic [57:0]        ss_ff;
   logic [63:0]        m2_ff;
   cull_type           cull_ff, cull_in;
   cull_type           cd_ff [0:CD-1];
   logic [63:0]        orv_in;
   logic signed [63:0] n_in [3];
   logic signed [63:0] nsh [3];
   logic [ttcp_pkg::NRM_BITS-1:0] am [3];

   always_comb begin
      orv_in = '0;
      for (int j = 0; j < 3; j++) begin
         orv_in = orv_in | (n_ff[j] ^ {64{n_ff[j][63]}});
      end
      n_in[0] = 64'(65'(cp_ff[0]) - 65'(cp_ff[1]));
      n_in[1] = 64'(65'(cp_ff[2]) - 65'(cp_ff[3]));
      n_in[2] = 64'(65'(cp_ff[4]) - 65'(cp_ff[5]));
      for (int j = 0; j < 3; j++) begin
         nsh[j] = nc_ff[j] >>> sh_ff;
         am[j]  = a_ff[j][ttcp_pkg::NRM_BITS-1] ? ttcp_pkg::NRM_BITS'(-a_ff[j])
                                                : ttcp_pkg::NRM_BITS'(a_ff[j]);
      end
   end

   always_comb begin
      logic [2:0] gsel;
      logic [2:0] bsel;
      logic       any;
      logic [7:0] byte_v;
      logic [6:0] blen;
      gsel = '0;
      bsel = '0;
      any  = 1'b0;
      for (int g = 0; g < 8; g++) begin
         if (grp_ff[g]) begin
            gsel = 3'(g);
            any  = 1'b1;
         end
      end
      byte_v = orv_ff[gsel*8 +: 8];
      for (int b = 0; b < 8; b++) begin
         if (byte_v[b]) begin
            bsel = 3'(b);
         end
      end
      blen  = any ? 7'({1'b0, gsel, bsel}) + 7'd1 : 7'd0;
      sh_in = (blen > 7'(ttcp_pkg::NRM_BITS - 1)) ? 6'(blen - 7'(ttcp_pkg::NRM_BITS - 1))
                                                   : 6'd0;
   end

   always_comb begin
      logic signed [61:0] dot;
      logic [3:0]         sh;
      dot = 62'(dp_ff[0]) + 62'(dp_ff[1]) + 62'(dp_ff[2]);
      sh  = '0;
      for (int k = 1; k <= ttcp_pkg::SHADE_STEPS; k++) begin
         if (66'(ss_ff) * 66'(k * k) <= 66'(m2_ff)) begin
            sh = 4'(k);
         end
      end
      if (!negz8_ff || sh == 4'(ttcp_pkg::SHADE_STEPS)) begin
         sh = '0;
      end
      cull_in.vis   = vis8_ff;
      cull_in.shade = sh;
      if (dot < 62'sd0) begin end
   end

   always_ff @(posedge clock) begin
      logic signed [61:0] dsum;
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            e1_ff[j] <= ttcp_pkg::sat32(64'(t_ff[1][j]) - 64'(t_ff[0][j]));
            e2_ff[j] <= ttcp_pkg::sat32(64'(t_ff[2][j]) - 64'(t_ff[0][j]));
            t0d_ff[ST_T+1][j] <= t_ff[0][j];
            for (int s = ST_T + 2; s <= ST_T + 6; s++) begin
               t0d_ff[s][j] <= t0d_ff[s-1][j];
            end
         end
         cp_ff[0] <= e1_ff[1] * e2_ff[2];
         cp_ff[1] <= e1_ff[2] * e2_ff[1];
         cp_ff[2] <= e1_ff[2] * e2_ff[0];
         cp_ff[3] <= e1_ff[0] * e2_ff[2];
         cp_ff[4] <= e1_ff[0] * e2_ff[1];
         cp_ff[5] <= e1_ff[1] * e2_ff[0];
         for (int j = 0; j < 3; j++) begin
            n_ff[j]  <= n_in[j];
            nb_ff[j] <= n_ff[j];
            nc_ff[j] <= nb_ff[j];
            a_ff[j]  <= nsh[j][ttcp_pkg::NRM_BITS-1:0];
            dp_ff[j] <= a_ff[j] * t0d_ff[ST_T+6][j];
            sq_ff[j] <= am[j] * am[j];
         end
         orv_ff <= orv_in;
         for (int g = 0; g < 8; g++) begin
            grp_ff[g] <= |orv_in[g*8 +: 8];
         end
         sh_ff    <= sh_in;
         negz7_ff <= a_ff[2][ttcp_pkg::NRM_BITS-1];
         dsum      = 62'(dp_ff[0]) + 62'(dp_ff[1]) + 62'(dp_ff[2]);
         vis8_ff  <= dsum < 62'sd0;
         negz8_ff <= negz7_ff;
         ss_ff    <= 58'(sq_ff[0]) + 58'(sq_ff[1]) + 58'(sq_ff[2]);
         m2_ff    <= 64'(sq_ff[2]) * 64'(ttcp_pkg::SHADE_STEPS * ttcp_pkg::SHADE_STEPS);
         cull_ff  <= cull_in;
         cd_ff[0] <= cull_ff;
         for (int s = 1; s < CD; s++) begin
            cd_ff[s] <= cd_ff[s-1];
         end
      end
   end

   // projection
   logic signed [63:0] px_ff [3], py_ff [3], pz_ff [3];
   logic signed [63:0] dx_ff [3], dy_ff [3], dz_ff [3];
   ttcp_pkg::q32_type  w5_ff [3], w6_ff [3];
   ttcp_pkg::q32_type  qx [3], qy [3], qz [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            px_ff[i] <= t_ff[i][0] * x_scale_ff;
            py_ff[i] <= t_ff[i][1] * y_scale_ff;
            pz_ff[i] <= t_ff[i][2] * z_scale_ff;
            w5_ff[i] <= t_ff[i][2];
            dx_ff[i] <= px_ff[i];
            dy_ff[i] <= py_ff[i];
            dz_ff[i] <= pz_ff[i] + (64'(z_offset_ff) <<< 16);
            w6_ff[i] <= w5_ff[i];
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_vtx
      ttcp_div u_div_x (.clock(clock), .en(adv), .num(dx_ff[i]), .den(w6_ff[i]), .quo(qx[i]));
      ttcp_div u_div_y (.clock(clock), .en(adv), .num(dy_ff[i]), .den(w6_ff[i]), .quo(qy[i]));
      ttcp_div u_div_z (.clock(clock), .en(adv), .num(dz_ff[i]), .den(w6_ff[i]), .quo(qz[i]));
   end

   // viewport and depth
   logic signed [VPW-1:0] vpx_ff [3], vpy_ff [3];
   logic signed [33:0]    dsum_ff;
   ttcp_pkg::q32_type     sx_ff [3], sy_ff [3];
   logic                  dneg_ff;
   logic [51:0]           dph_ff;
   logic [50:0]           dpl_ff;
   logic [32:0]           dmag;
   logic [66:0]           dprod;
   ttcp_pkg::q32_type     depth_in;

   always_comb begin
      dmag     = dsum_ff[33] ? 33'(-dsum_ff) : 33'(dsum_ff);
      dprod    = (67'(dph_ff) << 16) + 67'(dpl_ff);
      depth_in = dneg_ff ? 32'(-dprod[66:ttcp_pkg::DIV3_SHIFT])
                         : 32'(dprod[66:ttcp_pkg::DIV3_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            vpx_ff[i] <= (33'(qx[i]) + 33'sd65536) * SW_S;
            vpy_ff[i] <= (33'(qy[i]) + 33'sd65536) * SH_S;
            sx_ff[i]  <= ttcp_pkg::sat32(64'(vpx_ff[i] >>> 1));
            sy_ff[i]  <= ttcp_pkg::sat32(64'(vpy_ff[i] >>> 1));
         end
         dsum_ff <= 34'(qz[0]) + 34'(qz[1]) + 34'(qz[2]);
         dneg_ff <= dsum_ff[33];
         dph_ff  <= dmag[32:16] * ttcp_pkg::DIV3_RECIP;
         dpl_ff  <= dmag[15:0] * ttcp_pkg::DIV3_RECIP;
      end
   end

   // result register
   ttcp_pkg::q32_type s_ff [6];
   ttcp_pkg::q32_type depth_ff;
   logic [3:0]        shade_ff;
   logic              visible_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         visible_ff <= cd_ff[CD-1].vis;
         if (cd_ff[CD-1].vis) begin
            for (int i = 0; i < 3; i++) begin
               s_ff[2*i]   <= sx_ff[i];
               s_ff[2*i+1] <= sy_ff[i];
            end
            depth_ff <= depth_in;
            shade_ff <= cd_ff[CD-1].shade;
         end else begin
            for (int i = 0; i < 6; i++) begin
               s_ff[i] <= '0;
            end
            depth_ff <= '0;
            shade_ff <= '0;
         end
      end
   end

   assign rsp.valid   = vld_ff[ST_OUT];
   assign rsp.s0_x    = s_ff[0];
   assign rsp.s0_y    = s_ff[1];
   assign rsp.s1_x    = s_ff[2];
   assign rsp.s1_y    = s_ff[3];
   assign rsp.s2_x    = s_ff[4];
   assign rsp.s2_y    = s_ff[5];
   assign rsp.depth   = depth_ff;
   assign rsp.shade   = shade_ff;
   assign rsp.visible = visible_ff;

   `TTCP_ASSERT_RST(a_cull_zero, clock, reset, rsp.valid && !rsp.visible |-> rsp.depth == 32'sd0 && rsp.shade == 4'd0 && rsp.s0_x == 32'sd0, "culled beat has nonzero data")
   `TTCP_ASSERT_RST(a_shade_range, clock, reset, rsp.valid |-> rsp.shade < 4'(ttcp_pkg::SHADE_STEPS), "shade out of range")
   `TTCP_ASSERT(a_ready_flow, clock, req.ready == (!rsp.valid || rsp.ready), "ready does not follow result stall")

endmodule

`default_nettype wire
